@@ rtl/dlq_pkg.sv @@
package dlq_pkg;

   // Default pool size.
   localparam int POOL_ENTRIES_DEF = 256;

   // Operation codes of the request word.
   typedef enum logic [4:0] {
      OP_INIT      = 5'd0,
      OP_ENQ       = 5'd1,
      OP_DEQ       = 5'd2,
      OP_INS_AHEAD = 5'd3,
      OP_INS_AFTER = 5'd4,
      OP_REMOVE    = 5'd5,
      OP_SWAP      = 5'd6,
      OP_FIRST     = 5'd7,
      OP_LAST      = 5'd8,
      OP_NEXT      = 5'd9,
      OP_PREV      = 5'd10,
      OP_EMPTY     = 5'd11,
      OP_BLK_ENQ   = 5'd12,
      OP_BLK_AHEAD = 5'd13,
      OP_BLK_AFTER = 5'd14,
      OP_BLK_MOVE  = 5'd15,
      OP_COUNT     = 5'd16
   } op_type;

   // Entry kinds.
   localparam logic [1:0] KIND_UNUSED = 2'd0;
   localparam logic [1:0] KIND_HEADER = 2'd1;
   localparam logic [1:0] KIND_DATA   = 2'd2;
   localparam logic [1:0] KIND_DEL    = 2'd3;

   // Response status codes.
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NOT_HDR  = 2'd1;
   localparam logic [1:0] ST_NOT_DATA = 2'd2;
   localparam logic [1:0] ST_SAME     = 2'd3;

   // Which store a write step updates.
   typedef enum logic [1:0] {
      W_PREV = 2'd0,
      W_NEXT = 2'd1,
      W_KIND = 2'd2
   } wsel_type;

   // Write enables of the link memory.
   typedef struct packed {
      logic prev;
      logic next;
   } link_wen_type;

endpackage

@@ rtl/dlq_link_mem.sv @@
module dlq_link_mem #(
   parameter int DEPTH = dlq_pkg::POOL_ENTRIES_DEF,
   parameter int IDX_W = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  dlq_pkg::link_wen_type wen,
   input  logic [IDX_W-1:0]     wr_addr,
   input  logic [IDX_W-1:0]     wr_data,
   input  logic [IDX_W-1:0]     rd_addr,
   output logic [IDX_W-1:0]     rd_prev,
   output logic [IDX_W-1:0]     rd_next
);

   logic [IDX_W-1:0] prev_mem [DEPTH];
   logic [IDX_W-1:0] next_mem [DEPTH];
   logic [IDX_W-1:0] rd_prev_ff;
   logic [IDX_W-1:0] rd_next_ff;

   // Both link stores share one address on each port; reads are registered.
   always_ff @(posedge clock) begin
      if (wen.prev) begin
         prev_mem[wr_addr] <= wr_data;
      end
      if (wen.next) begin
         next_mem[wr_addr] <= wr_data;
      end
      rd_prev_ff <= prev_mem[rd_addr];
      rd_next_ff <= next_mem[rd_addr];
   end

   assign rd_prev = rd_prev_ff;
   assign rd_next = rd_next_ff;

endmodule

@@ rtl/dlq_kind_mem.sv @@
module dlq_kind_mem #(
   parameter int DEPTH = dlq_pkg::POOL_ENTRIES_DEF,
   parameter int IDX_W = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wen,
   input  logic [IDX_W-1:0] wr_addr,
   input  logic [1:0]       wr_data,
   input  logic [IDX_W-1:0] rd_addr,
   output logic [1:0]       rd_kind,
   output logic             clearing
);

   logic [1:0]       kind_mem [DEPTH];
   logic [1:0]       rd_kind_ff;
   logic             clearing_ff;
   logic             clearing_in;
   logic [IDX_W-1:0] clr_addr_ff;
   logic [IDX_W-1:0] clr_addr_in;

   // The sweep ends after the last entry has been cleared.
   always_comb begin
      clearing_in = clearing_ff;
      clr_addr_in = clr_addr_ff;
      if (clearing_ff) begin
         clr_addr_in = clr_addr_ff + IDX_W'(1);
         if (clr_addr_ff == IDX_W'(DEPTH - 1)) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clearing_ff <= clearing_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // The clearing sweep owns the write port until it is done.
   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         kind_mem[clr_addr_ff] <= dlq_pkg::KIND_UNUSED;
      end else if (wen) begin
         kind_mem[wr_addr] <= wr_data;
      end
      rd_kind_ff <= kind_mem[rd_addr];
   end

   assign rd_kind  = rd_kind_ff;
   assign clearing = clearing_ff;

endmodule

@@ rtl/doubly_linked_queue_manager.sv @@
// Channel   Ports                                         Handshake
// request   req_operation, req_first/second/third_entry   start high while busy low
// response  rsp_result_entry, rsp_found, rsp_entry_count,  rsp_strobe high one cycle
//           rsp_status
//
// An operation reads the three named entries and one linked entry and plans, then writes
// links one word per cycle, up to ten writes for swap; the response word comes as busy
// falls. Count walks the ring entry by entry through the single read port. After reset
// the kind memory is cleared one entry a cycle, with busy held high until the sweep is
// done. The receiver cannot stall; each response is shown once.
module doubly_linked_queue_manager #(
   parameter int POOL_ENTRIES = dlq_pkg::POOL_ENTRIES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [4:0] req_operation,
   input  logic [7:0] req_first_entry,
   input  logic [7:0] req_second_entry,
   input  logic [7:0] req_third_entry,
   output logic       rsp_strobe,
   output logic [7:0] rsp_result_entry,
   output logic       rsp_found,
   output logic [8:0] rsp_entry_count,
   output logic [1:0] rsp_status
);

   localparam int IDX_W = $clog2(POOL_ENTRIES);
   localparam int EW    = (IDX_W > 8) ? IDX_W : 8;
   localparam int NWR   = 10;

   typedef struct packed {
      dlq_pkg::wsel_type sel;
      logic [IDX_W-1:0]  adr;
      logic [IDX_W-1:0]  dat;
   } wr_type;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_RD_A, S_RD_B, S_RD_C, S_RD_X, S_CAP_X, S_PLAN,
      S_WR, S_CNT_RD, S_CNT_CHK
   } state_type;

   // Entry numbers wrap modulo the pool size, one compare and subtract per bit.
   function automatic logic [IDX_W-1:0] wrap_entry(input logic [7:0] v);
      logic [IDX_W:0] r;
      r = '0;
      for (int i = 7; i >= 0; i--) begin
         r = {r[IDX_W-1:0], v[i]};
         if (r >= (IDX_W+1)'(POOL_ENTRIES)) begin
            r = r - (IDX_W+1)'(POOL_ENTRIES);
         end
      end
      return r[IDX_W-1:0];
   endfunction

   function automatic logic [7:0] to_word(input logic [IDX_W-1:0] x);
      logic [EW-1:0] t;
      t = EW'(x);
      return t[7:0];
   endfunction

   function automatic wr_type mk(input dlq_pkg::wsel_type s,
                                 input logic [IDX_W-1:0] ad,
                                 input logic [IDX_W-1:0] d);
      wr_type w;
      w.sel = s;
      w.adr = ad;
      w.dat = d;
      return w;
   endfunction

   state_type          state_ff, state_in;
   dlq_pkg::op_type    op_ff, op_in;
   logic [IDX_W-1:0]   a_ff, a_in, b_ff, b_in, c_ff, c_in;
   logic [1:0]         ka_ff, ka_in, kb_ff, kb_in, kc_ff, kc_in, kx_ff, kx_in;
   logic [IDX_W-1:0]   pa_ff, pa_in, na_ff, na_in, pb_ff, pb_in, nb_ff, nb_in;
   logic [IDX_W-1:0]   pc_ff, pc_in, nc_ff, nc_in, px_ff, px_in, nx_ff, nx_in;
   logic [3:0]         step_ff, step_in;
   logic [IDX_W-1:0]   p_ff, p_in;
   logic [IDX_W:0]     steps_ff, steps_in;
   logic [8:0]         cnt_ff, cnt_in;
   logic               strobe_ff, strobe_in;
   logic [7:0]         res_ff, res_in;
   logic               found_ff, found_in;
   logic [8:0]         count_ff, count_in;
   logic [1:0]         status_ff, status_in;

   logic [IDX_W-1:0]   rd_addr;
   logic [IDX_W-1:0]   rd_prev, rd_next;
   logic [1:0]         rd_kind;
   logic               clearing;
   dlq_pkg::link_wen_type link_wen;
   logic               kind_wen;
   wr_type             cur_wr;

   // Plan of the operation, taken from the captured words.
   logic [1:0]         pl_status;
   logic [IDX_W-1:0]   pl_res;
   logic               pl_found;
   logic               do_init, do_det, do_plc, do_pre, do_spl, do_hclr;
   logic [IDX_W-1:0]   det_n, det_p, det_q, plc_n, plc_x, plc_y;
   logic [IDX_W-1:0]   spl_f, spl_l, spl_x, spl_y;
   wr_type             wl [NWR];
   logic [3:0]         wn;

   dlq_link_mem #(.DEPTH(POOL_ENTRIES), .IDX_W(IDX_W)) u_link (
      .clock   (clock),
      .wen     (link_wen),
      .wr_addr (cur_wr.adr),
      .wr_data (cur_wr.dat),
      .rd_addr (rd_addr),
      .rd_prev (rd_prev),
      .rd_next (rd_next)
   );

   dlq_kind_mem #(.DEPTH(POOL_ENTRIES), .IDX_W(IDX_W)) u_kind (
      .clock    (clock),
      .reset    (reset),
      .wen      (kind_wen),
      .wr_addr  (cur_wr.adr),
      .wr_data  (cur_wr.dat[1:0]),
      .rd_addr  (rd_addr),
      .rd_kind  (rd_kind),
      .clearing (clearing)
   );

   // Checks and the link rewrites each operation calls for.
   always_comb begin
      pl_status = dlq_pkg::ST_OK;
      pl_res    = '0;
      pl_found  = 1'b0;
      do_init   = 1'b0;
      do_det    = 1'b0;
      do_plc    = 1'b0;
      do_pre    = 1'b0;
      do_spl    = 1'b0;
      do_hclr   = 1'b0;
      det_n     = b_ff;
      det_p     = pb_ff;
      det_q     = nb_ff;
      plc_n     = a_ff;
      plc_x     = pb_ff;
      plc_y     = b_ff;
      spl_f     = na_ff;
      spl_l     = pa_ff;
      spl_x     = pb_ff;
      spl_y     = b_ff;
      unique case (op_ff)
         dlq_pkg::OP_INIT: begin
            do_init = 1'b1;
         end
         dlq_pkg::OP_ENQ, dlq_pkg::OP_INS_AHEAD, dlq_pkg::OP_INS_AFTER: begin
            if (op_ff == dlq_pkg::OP_ENQ && kb_ff != dlq_pkg::KIND_HEADER) begin
               pl_status = dlq_pkg::ST_NOT_HDR;
            end else if (a_ff == b_ff) begin
               pl_status = dlq_pkg::ST_SAME;
            end else begin
               do_plc = 1'b1;
               if (op_ff == dlq_pkg::OP_INS_AFTER) begin
                  plc_x = b_ff;
                  plc_y = nb_ff;
               end
            end
         end
         dlq_pkg::OP_DEQ: begin
            if (kb_ff != dlq_pkg::KIND_HEADER) begin
               pl_status = dlq_pkg::ST_NOT_HDR;
            end else if (nb_ff != b_ff) begin
               if (kx_ff != dlq_pkg::KIND_DATA) begin
                  pl_status = dlq_pkg::ST_NOT_DATA;
               end else begin
                  do_det   = 1'b1;
                  det_n    = nb_ff;
                  det_p    = px_ff;
                  det_q    = nx_ff;
                  pl_res   = nb_ff;
                  pl_found = 1'b1;
               end
            end
         end
         dlq_pkg::OP_REMOVE: begin
            if (ka_ff != dlq_pkg::KIND_DATA) begin
               pl_status = dlq_pkg::ST_NOT_DATA;
            end else begin
               do_det = 1'b1;
               det_n  = a_ff;
               det_p  = pa_ff;
               det_q  = na_ff;
            end
         end
         dlq_pkg::OP_SWAP: begin
            if (kb_ff != dlq_pkg::KIND_DATA) begin
               pl_status = dlq_pkg::ST_NOT_DATA;
            end else if (a_ff == b_ff) begin
               pl_status = dlq_pkg::ST_SAME;
            end else begin
               do_det = 1'b1;
               do_plc = 1'b1;
               plc_y  = nb_ff;
            end
         end
         dlq_pkg::OP_FIRST, dlq_pkg::OP_LAST: begin
            if (kb_ff != dlq_pkg::KIND_HEADER) begin
               pl_status = dlq_pkg::ST_NOT_HDR;
            end else if (nb_ff != b_ff) begin
               pl_res   = (op_ff == dlq_pkg::OP_FIRST) ? nb_ff : pb_ff;
               pl_found = 1'b1;
            end
         end
         dlq_pkg::OP_NEXT, dlq_pkg::OP_PREV: begin
            if (kx_ff == dlq_pkg::KIND_DATA) begin
               pl_res   = (op_ff == dlq_pkg::OP_NEXT) ? na_ff : pa_ff;
               pl_found = 1'b1;
            end
         end
         dlq_pkg::OP_EMPTY, dlq_pkg::OP_COUNT: begin
            if (kb_ff != dlq_pkg::KIND_HEADER) begin
               pl_status = dlq_pkg::ST_NOT_HDR;
            end else if (op_ff == dlq_pkg::OP_EMPTY) begin
               pl_found = (nb_ff == b_ff);
            end
         end
         dlq_pkg::OP_BLK_ENQ: begin
            if (ka_ff != dlq_pkg::KIND_HEADER || kb_ff != dlq_pkg::KIND_HEADER) begin
               pl_status = dlq_pkg::ST_NOT_HDR;
            end else if (a_ff == b_ff) begin
               pl_status = dlq_pkg::ST_SAME;
            end else if (na_ff != a_ff) begin
               do_spl  = 1'b1;
               do_hclr = 1'b1;
            end
         end
         dlq_pkg::OP_BLK_AHEAD, dlq_pkg::OP_BLK_AFTER: begin
            if (ka_ff != dlq_pkg::KIND_HEADER) begin
               pl_status = dlq_pkg::ST_NOT_HDR;
            end else if (kb_ff != dlq_pkg::KIND_DATA) begin
               pl_status = dlq_pkg::ST_NOT_DATA;
            end else if (na_ff != a_ff) begin
               do_spl  = 1'b1;
               do_hclr = 1'b1;
               if (op_ff == dlq_pkg::OP_BLK_AFTER) begin
                  spl_x = b_ff;
                  spl_y = nb_ff;
               end
            end
         end
         dlq_pkg::OP_BLK_MOVE: begin
            if (kc_ff != dlq_pkg::KIND_HEADER || kb_ff != dlq_pkg::KIND_HEADER) begin
               pl_status = dlq_pkg::ST_NOT_HDR;
            end else if (ka_ff != dlq_pkg::KIND_DATA) begin
               pl_status = dlq_pkg::ST_NOT_DATA;
            end else if (nc_ff != c_ff) begin
               do_pre = 1'b1;
               do_spl = 1'b1;
               spl_f  = a_ff;
               spl_l  = pc_ff;
               // The closing of the source ring has just rewritten prev of c.
               spl_x  = (b_ff == c_ff) ? pa_ff : pb_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // Ordered list of single-word writes, applied one per cycle.
   always_comb begin
      wn = '0;
      for (int i = 0; i < NWR; i++) begin
         wl[i] = '0;
      end
      if (do_init) begin
         wl[wn] = mk(dlq_pkg::W_KIND, b_ff, IDX_W'(dlq_pkg::KIND_HEADER)); wn = wn + 4'd1;
         wl[wn] = mk(dlq_pkg::W_PREV, b_ff, b_ff); wn = wn + 4'd1;
         wl[wn] = mk(dlq_pkg::W_NEXT, b_ff, b_ff); wn = wn + 4'd1;
      end
      if (do_det) begin
         wl[wn] = mk(dlq_pkg::W_NEXT, det_p, det_q); wn = wn + 4'd1;
         wl[wn] = mk(dlq_pkg::W_PREV, det_q, det_p); wn = wn + 4'd1;
         wl[wn] = mk(dlq_pkg::W_KIND, det_n, IDX_W'(dlq_pkg::KIND_DEL)); wn = wn + 4'd1;
         wl[wn] = mk(dlq_pkg::W_PREV, det_n, det_n); wn = wn + 4'd1;
         wl[wn] = mk(dlq_pkg::W_NEXT, det_n, det_n); wn = wn + 4'd1;
      end
      if (do_plc) begin
         wl[wn] = mk(dlq_pkg::W_KIND, plc_n, IDX_W'(dlq_pkg::KIND_DATA)); wn = wn + 4'd1;
         wl[wn] = mk(dlq_pkg::W_PREV, plc_n, plc_x); wn = wn + 4'd1;
         wl[wn] = mk(dlq_pkg::W_NEXT, plc_n, plc_y); wn = wn + 4'd1;
         wl[wn] = mk(dlq_pkg::W_PREV, plc_y, plc_n); wn = wn + 4'd1;
         wl[wn] = mk(dlq_pkg::W_NEXT, plc_x, plc_n); wn = wn + 4'd1;
      end
      if (do_pre) begin
         wl[wn] = mk(dlq_pkg::W_NEXT, pa_ff, c_ff); wn = wn + 4'd1;
         wl[wn] = mk(dlq_pkg::W_PREV, c_ff, pa_ff); wn = wn + 4'd1;
      end
      if (do_spl) begin
         wl[wn] = mk(dlq_pkg::W_NEXT, spl_x, spl_f); wn = wn + 4'd1;
         wl[wn] = mk(dlq_pkg::W_PREV, spl_f, spl_x); wn = wn + 4'd1;
         wl[wn] = mk(dlq_pkg::W_NEXT, spl_l, spl_y); wn = wn + 4'd1;
         wl[wn] = mk(dlq_pkg::W_PREV, spl_y, spl_l); wn = wn + 4'd1;
      end
      if (do_hclr) begin
         wl[wn] = mk(dlq_pkg::W_PREV, a_ff, a_ff); wn = wn + 4'd1;
         wl[wn] = mk(dlq_pkg::W_NEXT, a_ff, a_ff); wn = wn + 4'd1;
      end
   end

   // Memory port drive.
   assign cur_wr        = wl[step_ff];
   assign link_wen.prev = (state_ff == S_WR) && (cur_wr.sel == dlq_pkg::W_PREV);
   assign link_wen.next = (state_ff == S_WR) && (cur_wr.sel == dlq_pkg::W_NEXT);
   assign kind_wen      = (state_ff == S_WR) && (cur_wr.sel == dlq_pkg::W_KIND);

   always_comb begin
      unique case (state_ff)
         S_RD_A:   rd_addr = a_ff;
         S_RD_B:   rd_addr = b_ff;
         S_RD_C:   rd_addr = c_ff;
         S_RD_X: begin
            if (op_ff == dlq_pkg::OP_NEXT) begin
               rd_addr = na_ff;
            end else if (op_ff == dlq_pkg::OP_PREV) begin
               rd_addr = pa_ff;
            end else begin
               rd_addr = nb_ff;
            end
         end
         S_CNT_RD: rd_addr = p_ff;
         default:  rd_addr = a_ff;
      endcase
   end

   // Sequencer: read phase, plan, a write phase or ring walk where one is needed, then response.
   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      a_in      = a_ff;
      b_in      = b_ff;
      c_in      = c_ff;
      ka_in     = ka_ff;
      pa_in     = pa_ff;
      na_in     = na_ff;
      kb_in     = kb_ff;
      pb_in     = pb_ff;
      nb_in     = nb_ff;
      kc_in     = kc_ff;
      pc_in     = pc_ff;
      nc_in     = nc_ff;
      kx_in     = kx_ff;
      px_in     = px_ff;
      nx_in     = nx_ff;
      step_in   = step_ff;
      p_in      = p_ff;
      steps_in  = steps_ff;
      cnt_in    = cnt_ff;
      strobe_in = 1'b0;
      res_in    = res_ff;
      found_in  = found_ff;
      count_in  = count_ff;
      status_in = status_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (!clearing) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               op_in    = dlq_pkg::op_type'(req_operation);
               a_in     = wrap_entry(req_first_entry);
               b_in     = wrap_entry(req_second_entry);
               c_in     = wrap_entry(req_third_entry);
               state_in = S_RD_A;
            end
         end
         S_RD_A: state_in = S_RD_B;
         S_RD_B: begin
            ka_in    = rd_kind;
            pa_in    = rd_prev;
            na_in    = rd_next;
            state_in = S_RD_C;
         end
         S_RD_C: begin
            kb_in    = rd_kind;
            pb_in    = rd_prev;
            nb_in    = rd_next;
            state_in = S_RD_X;
         end
         S_RD_X: begin
            kc_in    = rd_kind;
            pc_in    = rd_prev;
            nc_in    = rd_next;
            state_in = S_CAP_X;
         end
         S_CAP_X: begin
            kx_in    = rd_kind;
            px_in    = rd_prev;
            nx_in    = rd_next;
            state_in = S_PLAN;
         end
         S_PLAN: begin
            step_in  = '0;
            p_in     = nb_ff;
            steps_in = '0;
            cnt_in   = '0;
            if (op_ff == dlq_pkg::OP_COUNT && pl_status == dlq_pkg::ST_OK) begin
               state_in = S_CNT_RD;
            end else if (wn != 4'd0) begin
               state_in = S_WR;
            end else begin
               state_in  = S_IDLE;
               strobe_in = 1'b1;
               res_in    = to_word(pl_res);
               found_in  = pl_found;
               count_in  = '0;
               status_in = pl_status;
            end
         end
         S_WR: begin
            step_in = step_ff + 4'd1;
            if (step_in == wn) begin
               state_in  = S_IDLE;
               strobe_in = 1'b1;
               res_in    = to_word(pl_res);
               found_in  = pl_found;
               count_in  = '0;
               status_in = pl_status;
            end
         end
         S_CNT_RD: state_in = S_CNT_CHK;
         S_CNT_CHK: begin
            if (steps_ff < (IDX_W+1)'(POOL_ENTRIES) && p_ff != b_ff
                  && rd_kind == dlq_pkg::KIND_DATA) begin
               if (cnt_ff != 9'd511) begin
                  cnt_in = cnt_ff + 9'd1;
               end
               p_in     = rd_next;
               steps_in = steps_ff + (IDX_W+1)'(1);
               state_in = S_CNT_RD;
            end else begin
               state_in  = S_IDLE;
               strobe_in = 1'b1;
               res_in    = '0;
               found_in  = 1'b0;
               count_in  = cnt_ff;
               status_in = dlq_pkg::ST_OK;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLEAR;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
      op_ff     <= op_in;
      a_ff      <= a_in;
      b_ff      <= b_in;
      c_ff      <= c_in;
      ka_ff     <= ka_in;
      pa_ff     <= pa_in;
      na_ff     <= na_in;
      kb_ff     <= kb_in;
      pb_ff     <= pb_in;
      nb_ff     <= nb_in;
      kc_ff     <= kc_in;
      pc_ff     <= pc_in;
      nc_ff     <= nc_in;
      kx_ff     <= kx_in;
      px_ff     <= px_in;
      nx_ff     <= nx_in;
      step_ff   <= step_in;
      p_ff      <= p_in;
      steps_ff  <= steps_in;
      cnt_ff    <= cnt_in;
      res_ff    <= res_in;
      found_ff  <= found_in;
      count_ff  <= count_in;
      status_ff <= status_in;
   end

   assign busy             = (state_ff != S_IDLE);
   assign rsp_strobe       = strobe_ff;
   assign rsp_result_entry = res_ff;
   assign rsp_found        = found_ff;
   assign rsp_entry_count  = count_ff;
   assign rsp_status       = status_ff;

   // A response word is shown for a single cycle.
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("response strobe held longer than one cycle");

   // A failed check reports no entry and no count.
   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_status != dlq_pkg::ST_OK) |->
         (rsp_result_entry == 8'd0 && !rsp_found && rsp_entry_count == 9'd0))
      else $error("error response carries data");

   // The write phase never runs past the planned list.
   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WR) |-> (step_ff < wn))
      else $error("write step beyond planned writes");

   // No memory write happens while the kind store is being cleared.
   a_no_write_clear: assert property (@(posedge clock) disable iff (reset)
      clearing |-> (!kind_wen && !link_wen.prev && !link_wen.next))
      else $error("write during clearing sweep");

endmodule

@@ tb/sv/testbench.sv @@
module testbench;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int POOL = 256;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int DRAIN_CYCLES = 600;

   typedef struct packed {
      logic [4:0] op;
      logic [7:0] a;
      logic [7:0] b;
      logic [7:0] c;
   } req_word_type;

   typedef struct packed {
      logic [7:0] entry;
      logic       found;
      logic [8:0] count;
      logic [1:0] status;
   } rsp_word_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic       busy;
   logic [4:0] req_operation = '0;
   logic [7:0] req_first_entry = '0;
   logic [7:0] req_second_entry = '0;
   logic [7:0] req_third_entry = '0;
   logic       rsp_strobe;
   logic [7:0] rsp_result_entry;
   logic       rsp_found;
   logic [8:0] rsp_entry_count;
   logic [1:0] rsp_status;

   req_word_type pending_words[$];
   rsp_word_type expected_words[$];
   int           error_count = 0;
   int           cycle_count = 0;

   // Shadow copy of the link pool, with flags for links that have been written.
   logic [7:0] shadow_prev[POOL];
   logic [7:0] shadow_next[POOL];
   logic [1:0] shadow_kind[POOL];
   bit         prev_written[POOL];
   bit         next_written[POOL];

   doubly_linked_queue_manager DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_operation(req_operation), .req_first_entry(req_first_entry),
      .req_second_entry(req_second_entry), .req_third_entry(req_third_entry),
      .rsp_strobe(rsp_strobe), .rsp_result_entry(rsp_result_entry),
      .rsp_found(rsp_found), .rsp_entry_count(rsp_entry_count),
      .rsp_status(rsp_status)
   );

   always #4 clock = ~clock;

   function automatic void set_next(logic [7:0] x, logic [7:0] v);
      shadow_next[x] = v;
      next_written[x] = 1'b1;
   endfunction

   function automatic void set_prev(logic [7:0] x, logic [7:0] v);
      shadow_prev[x] = v;
      prev_written[x] = 1'b1;
   endfunction

   function automatic void join_links(logic [7:0] x, logic [7:0] y);
      set_next(x, y);
      set_prev(y, x);
   endfunction

   // Take an entry out of its ring and leave it self-linked and deleted.
   function automatic void unlink_entry(logic [7:0] n);
      join_links(shadow_prev[n], shadow_next[n]);
      shadow_kind[n] = dlq_pkg::KIND_DEL;
      set_prev(n, n);
      set_next(n, n);
   endfunction

   function automatic void link_between(logic [7:0] n, logic [7:0] x, logic [7:0] y);
      shadow_kind[n] = dlq_pkg::KIND_DATA;
      set_prev(n, x);
      set_next(n, y);
      set_prev(y, n);
      set_next(x, n);
   endfunction

   function automatic void empty_header(logic [7:0] h);
      set_prev(h, h);
      set_next(h, h);
   endfunction

   function automatic string show_word(rsp_word_type w);
      return $sformatf("entry %0d found %0d count %0d status %0d",
                       w.entry, w.found, w.count, w.status);
   endfunction

   // Apply one operation to the shadow pool and return the response it gives.
   function automatic rsp_word_type queue_op_result(req_word_type r);
      rsp_word_type w;
      logic [7:0]   a, b, c, p, n, sf, sl;
      int           steps;
      w = '0;
      a = r.a;
      b = r.b;
      c = r.c;
      case (r.op)
         dlq_pkg::OP_INIT: begin
            shadow_kind[b] = dlq_pkg::KIND_HEADER;
            empty_header(b);
         end
         dlq_pkg::OP_ENQ: begin
            if (shadow_kind[b] != dlq_pkg::KIND_HEADER) w.status = dlq_pkg::ST_NOT_HDR;
            else if (a == b) w.status = dlq_pkg::ST_SAME;
            else link_between(a, shadow_prev[b], b);
         end
         dlq_pkg::OP_DEQ: begin
            if (shadow_kind[b] != dlq_pkg::KIND_HEADER) w.status = dlq_pkg::ST_NOT_HDR;
            else if (shadow_next[b] != b) begin
               n = shadow_next[b];
               if (shadow_kind[n] != dlq_pkg::KIND_DATA) w.status = dlq_pkg::ST_NOT_DATA;
               else begin
                  unlink_entry(n);
                  w.entry = n;
                  w.found = 1'b1;
               end
            end
         end
         dlq_pkg::OP_INS_AHEAD: begin
            if (a == b) w.status = dlq_pkg::ST_SAME;
            else link_between(a, shadow_prev[b], b);
         end
         dlq_pkg::OP_INS_AFTER: begin
            if (a == b) w.status = dlq_pkg::ST_SAME;
            else link_between(a, b, shadow_next[b]);
         end
         dlq_pkg::OP_REMOVE: begin
            if (shadow_kind[a] != dlq_pkg::KIND_DATA) w.status = dlq_pkg::ST_NOT_DATA;
            else unlink_entry(a);
         end
         dlq_pkg::OP_SWAP: begin
            if (shadow_kind[b] != dlq_pkg::KIND_DATA) w.status = dlq_pkg::ST_NOT_DATA;
            else if (a == b) w.status = dlq_pkg::ST_SAME;
            else begin
               p = shadow_prev[b];
               n = shadow_next[b];
               unlink_entry(b);
               link_between(a, p, n);
            end
         end
         dlq_pkg::OP_FIRST, dlq_pkg::OP_LAST: begin
            if (shadow_kind[b] != dlq_pkg::KIND_HEADER) w.status = dlq_pkg::ST_NOT_HDR;
            else if (shadow_next[b] != b) begin
               w.entry = (r.op == dlq_pkg::OP_FIRST) ? shadow_next[b] : shadow_prev[b];
               w.found = 1'b1;
            end
         end
         dlq_pkg::OP_NEXT, dlq_pkg::OP_PREV: begin
            n = (r.op == dlq_pkg::OP_NEXT) ? shadow_next[a] : shadow_prev[a];
            if (shadow_kind[n] == dlq_pkg::KIND_DATA) begin
               w.entry = n;
               w.found = 1'b1;
            end
         end
         dlq_pkg::OP_EMPTY: begin
            if (shadow_kind[b] != dlq_pkg::KIND_HEADER) w.status = dlq_pkg::ST_NOT_HDR;
            else w.found = (shadow_next[b] == b);
         end
         dlq_pkg::OP_BLK_ENQ: begin
            if (shadow_kind[a] != dlq_pkg::KIND_HEADER
                || shadow_kind[b] != dlq_pkg::KIND_HEADER)
               w.status = dlq_pkg::ST_NOT_HDR;
            else if (a == b) w.status = dlq_pkg::ST_SAME;
            else if (shadow_next[a] != a) begin
               sf = shadow_next[a];
               sl = shadow_prev[a];
               join_links(shadow_prev[b], sf);
               join_links(sl, b);
               empty_header(a);
            end
         end
         dlq_pkg::OP_BLK_AHEAD, dlq_pkg::OP_BLK_AFTER: begin
            if (shadow_kind[a] != dlq_pkg::KIND_HEADER) w.status = dlq_pkg::ST_NOT_HDR;
            else if (shadow_kind[b] != dlq_pkg::KIND_DATA) w.status = dlq_pkg::ST_NOT_DATA;
            else if (shadow_next[a] != a) begin
               sf = shadow_next[a];
               sl = shadow_prev[a];
               if (r.op == dlq_pkg::OP_BLK_AHEAD) begin
                  join_links(shadow_prev[b], sf);
                  join_links(sl, b);
               end else begin
                  n = shadow_next[b];
                  join_links(b, sf);
                  join_links(sl, n);
               end
               empty_header(a);
            end
         end
         dlq_pkg::OP_BLK_MOVE: begin
            if (shadow_kind[c] != dlq_pkg::KIND_HEADER
                || shadow_kind[b] != dlq_pkg::KIND_HEADER)
               w.status = dlq_pkg::ST_NOT_HDR;
            else if (shadow_kind[a] != dlq_pkg::KIND_DATA) w.status = dlq_pkg::ST_NOT_DATA;
            else if (shadow_next[c] != c) begin
               sl = shadow_prev[c];
               join_links(shadow_prev[a], c);
               join_links(shadow_prev[b], a);
               join_links(sl, b);
            end
         end
         dlq_pkg::OP_COUNT: begin
            if (shadow_kind[b] != dlq_pkg::KIND_HEADER) w.status = dlq_pkg::ST_NOT_HDR;
            else begin
               p = shadow_next[b];
               steps = 0;
               while (steps < POOL && p != b && shadow_kind[p] == dlq_pkg::KIND_DATA) begin
                  if (w.count < 9'd511) w.count = w.count + 9'd1;
                  p = shadow_next[p];
                  steps++;
               end
            end
         end
         default: ;
      endcase
      return w;
   endfunction

   // Queue one word with its predicted response. Operands that would read a
   // link never written are steered to header 0, which is set up first.
   task automatic send_word(logic [4:0] op, logic [7:0] a, logic [7:0] b, logic [7:0] c);
      req_word_type r;
      r = '{op: op, a: a, b: b, c: c};
      if (op == dlq_pkg::OP_INS_AHEAD && !prev_written[b]) r.b = 8'd0;
      if (op == dlq_pkg::OP_INS_AFTER && !next_written[b]) r.b = 8'd0;
      if (op == dlq_pkg::OP_NEXT && !next_written[a]) r.a = 8'd0;
      if (op == dlq_pkg::OP_PREV && !prev_written[a]) r.a = 8'd0;
      expected_words.push_back(queue_op_result(r));
      pending_words.push_back(r);
   endtask

   // Random entry of the wanted kind from the working range, if one turns up.
   function automatic logic [7:0] pick_kind(logic [1:0] k, int lo, int hi);
      logic [7:0] e;
      for (int i = 0; i < 24; i++) begin
         e = 8'($urandom_range(lo, hi));
         if (shadow_kind[e] == k) return e;
      end
      return 8'($urandom_range(lo, hi));
   endfunction

   function automatic logic [7:0] pick_free();
      logic [7:0] e;
      for (int i = 0; i < 24; i++) begin
         e = 8'($urandom_range(8, 47));
         if (shadow_kind[e] != dlq_pkg::KIND_DATA
             && shadow_kind[e] != dlq_pkg::KIND_HEADER) return e;
      end
      return 8'($urandom_range(8, 47));
   endfunction

   task automatic send_random();
      int         sel;
      logic [7:0] h, d;
      sel = $urandom_range(0, 99);
      h = pick_kind(dlq_pkg::KIND_HEADER, 0, 7);
      d = pick_kind(dlq_pkg::KIND_DATA, 8, 47);
      if (sel < 22) send_word(dlq_pkg::OP_ENQ, pick_free(), h, 8'd0);
      else if (sel < 32) send_word(dlq_pkg::OP_DEQ, 8'd0, h, 8'd0);
      else if (sel < 37) send_word(dlq_pkg::OP_INS_AHEAD, pick_free(), d, 8'd0);
      else if (sel < 42) send_word(dlq_pkg::OP_INS_AFTER, pick_free(), d, 8'd0);
      else if (sel < 47) send_word(dlq_pkg::OP_REMOVE, d, 8'd0, 8'd0);
      else if (sel < 51) send_word(dlq_pkg::OP_SWAP, pick_free(), d, 8'd0);
      else if (sel < 54) send_word(dlq_pkg::OP_FIRST, 8'd0, h, 8'd0);
      else if (sel < 57) send_word(dlq_pkg::OP_LAST, 8'd0, h, 8'd0);
      else if (sel < 60) send_word(dlq_pkg::OP_NEXT, d, 8'd0, 8'd0);
      else if (sel < 63) send_word(dlq_pkg::OP_PREV, d, 8'd0, 8'd0);
      else if (sel < 66) send_word(dlq_pkg::OP_EMPTY, 8'd0, h, 8'd0);
      else if (sel < 72) send_word(dlq_pkg::OP_COUNT, 8'd0, h, 8'd0);
      else if (sel < 75)
         send_word(dlq_pkg::OP_BLK_ENQ, h, pick_kind(dlq_pkg::KIND_HEADER, 0, 7), 8'd0);
      else if (sel < 78) send_word(dlq_pkg::OP_BLK_AHEAD, h, d, 8'd0);
      else if (sel < 81) send_word(dlq_pkg::OP_BLK_AFTER, h, d, 8'd0);
      else if (sel < 85)
         send_word(dlq_pkg::OP_BLK_MOVE, d, pick_kind(dlq_pkg::KIND_HEADER, 0, 7), h);
      else if (sel < 87)
         send_word(dlq_pkg::OP_INIT, 8'd0, 8'($urandom_range(0, 7)), 8'd0);
      else
         // Noise over the whole field ranges, unused operation codes included.
         send_word(5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
   endtask

   task automatic wait_drained();
      while (pending_words.size() != 0 || expected_words.size() != 0)
         @(posedge clock);
   endtask

   // Driver: bursts of words with random gaps between them.
   always @(posedge clock) begin : word_driver
      req_word_type w;
      int           burst_left;
      int           gap_left;
      if (reset) begin
         start <= 1'b0;
         burst_left = 0;
         gap_left = 0;
      end else if (!start || !busy) begin
         if (gap_left != 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (pending_words.size() != 0) begin
            w = pending_words.pop_front();
            start <= 1'b1;
            req_operation <= w.op;
            req_first_entry <= w.a;
            req_second_entry <= w.b;
            req_third_entry <= w.c;
            if (burst_left <= 1) begin
               burst_left = $urandom_range(1, 12);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
            end else begin
               burst_left--;
            end
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: every response word is checked against the oldest prediction.
   always @(posedge clock) begin : rsp_monitor
      rsp_word_type got, want;
      if (!reset && rsp_strobe) begin
         got = '{entry: rsp_result_entry, found: rsp_found,
                 count: rsp_entry_count, status: rsp_status};
         if (expected_words.size() == 0) begin
            $display("%0t: response with none expected: %s", $time, show_word(got));
            error_count++;
         end else begin
            want = expected_words.pop_front();
            if (got !== want) begin
               $display("%0t: mismatch: expected %s, got %s",
                        $time, show_word(want), show_word(got));
               error_count++;
            end
         end
      end
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      for (int i = 0; i < POOL; i++) begin
         shadow_kind[i] = dlq_pkg::KIND_UNUSED;
         shadow_prev[i] = '0;
         shadow_next[i] = '0;
      end

      // Directed part: basic ring operations, checks and extremes.
      send_word(dlq_pkg::OP_INIT, 8'd0, 8'd0, 8'd0);
      send_word(dlq_pkg::OP_INIT, 8'd0, 8'd1, 8'd0);
      send_word(dlq_pkg::OP_INIT, 8'd0, 8'd255, 8'd0);
      send_word(dlq_pkg::OP_EMPTY, 8'd0, 8'd0, 8'd0);
      send_word(dlq_pkg::OP_DEQ, 8'd0, 8'd0, 8'd0);
      send_word(dlq_pkg::OP_ENQ, 8'd8, 8'd0, 8'd0);
      send_word(dlq_pkg::OP_ENQ, 8'd255, 8'd0, 8'd0);
      send_word(dlq_pkg::OP_ENQ, 8'd9, 8'd0, 8'd0);
      send_word(dlq_pkg::OP_INS_AHEAD, 8'd10, 8'd9, 8'd0);
      send_word(dlq_pkg::OP_INS_AFTER, 8'd11, 8'd8, 8'd0);
      send_word(dlq_pkg::OP_FIRST, 8'd0, 8'd0, 8'd0);
      send_word(dlq_pkg::OP_LAST, 8'd0, 8'd0, 8'd0);
      send_word(dlq_pkg::OP_NEXT, 8'd8, 8'd0, 8'd0);
      send_word(dlq_pkg::OP_PREV, 8'd8, 8'd0, 8'd0);
      send_word(dlq_pkg::OP_COUNT, 8'd0, 8'd0, 8'd0);
      send_word(dlq_pkg::OP_SWAP, 8'd12, 8'd10, 8'd0);
      send_word(dlq_pkg::OP_REMOVE, 8'd11, 8'd0, 8'd0);
      send_word(dlq_pkg::OP_DEQ, 8'd0, 8'd0, 8'd0);
      send_word(dlq_pkg::OP_ENQ, 8'd8, 8'd2, 8'd0);
      send_word(dlq_pkg::OP_ENQ, 8'd0, 8'd0, 8'd0);
      send_word(dlq_pkg::OP_SWAP, 8'd5, 8'd5, 8'd0);
      send_word(dlq_pkg::OP_BLK_ENQ, 8'd1, 8'd0, 8'd0);
      send_word(dlq_pkg::OP_BLK_ENQ, 8'd0, 8'd1, 8'd0);
      send_word(dlq_pkg::OP_ENQ, 8'd13, 8'd255, 8'd0);
      send_word(dlq_pkg::OP_BLK_AFTER, 8'd255, 8'd9, 8'd0);
      send_word(dlq_pkg::OP_BLK_MOVE, 8'd9, 8'd255, 8'd1);
      send_word(dlq_pkg::OP_COUNT, 8'd0, 8'd255, 8'd0);
      send_word(5'd31, 8'd255, 8'd255, 8'd255);

      @(negedge reset);
      for (int i = 0; i < 450; i++) begin
         send_random();
         // Somewhere in the middle, hold off until the block has gone quiet.
         if (i == 200) wait_drained();
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
   end

endmodule
